/* sv/blp_pkg.sv */
// Shared types and constants for the billboard label projection block.
`default_nettype none
package blp_pkg;

    localparam int IN_DATA_W   = 248;
    localparam int IN_USER_W   = 1;
    localparam int OUT_DATA_W  = 80;
    localparam int OUT_USER_W  = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int ICON_COUNT_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Quotient bits produced by every divider pipeline.
    localparam int DIV_Q_W = 14;

    localparam logic [CFG_IDX_W-1:0] REG_PLATES_ENABLED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACE_ICONS_READY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIDE_DISTANCE_SQ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_DISTANCE_SQ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_DISTANCE_SQ  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE        = 3'd6;

    localparam logic [31:0] HIDE_DISTANCE_SQ_RST = 32'd1690000;
    localparam logic [31:0] NEAR_DISTANCE_SQ_RST = 32'd160000;
    localparam logic [31:0] FAR_DISTANCE_SQ_RST  = 32'd1000000;
    localparam logic [8:0]  MIN_SCALE_RST        = 9'd115;
    localparam logic [8:0]  MAX_SCALE_RST        = 9'd294;

    localparam logic [22:0] MIN_CAM_DISTANCE = 23'd256;
    localparam logic signed [25:0] HEAD_HEIGHT = 26'sd14080;

    localparam logic signed [15:0] CENTRE_X_Q4 = 16'sd15360;
    localparam logic signed [15:0] CENTRE_Y_Q4 = 16'sd8640;
    localparam logic [14:0] LEFT_MAX_Q4 = 15'd29440;
    localparam logic [14:0] LEFT_MIN_Q4 = 15'd1280;
    localparam logic [13:0] TOP_MIN_Q4  = 14'd960;
    localparam logic [13:0] TOP_MAX_Q4  = 14'd15680;

    typedef struct packed {
        logic        plates_enabled;
        logic        face_icons_ready;
        logic [31:0] hide_distance_sq;
        logic [31:0] near_distance_sq;
        logic [31:0] far_distance_sq;
        logic [8:0]  min_scale;
        logic [8:0]  max_scale;
    } cfg_t;

    // One classified label request, as held in the queue.
    typedef struct packed {
        logic               en;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic signed [24:0] dz;
        logic signed [25:0] rx;
        logic signed [25:0] ry;
        logic signed [25:0] rz;
        logic signed [23:0] cx;
        logic signed [23:0] cz;
        logic [22:0]        r;
        logic               icon_valid;
        logic [7:0]         icon_index;
        logic               opponent;
    } item_t;

endpackage
`default_nettype wire

/* sv/blp_queue.sv */
// Short queue of classified label requests between front and back.
`default_nettype none
module blp_queue #(
    parameter int DEPTH = blp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire blp_pkg::item_t push_item,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output blp_pkg::item_t     head_item
);
    import blp_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/blp_front.sv */
// Front end: accepts input beats, forms differences and classifies the request.
`default_nettype none
module blp_front #(
    parameter int ICON_COUNT = blp_pkg::ICON_COUNT_DEF
) (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [blp_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [blp_pkg::IN_USER_W-1:0] s_tuser,
    input  wire blp_pkg::cfg_t                 cfg,
    input  wire logic                          queue_full,
    output logic                               push,
    output blp_pkg::item_t                     item
);
    import blp_pkg::*;

    logic signed [23:0] target_x, target_y, target_z;
    logic signed [23:0] viewer_x, viewer_y, viewer_z;
    logic signed [23:0] cam_offset_x, cam_offset_y, cam_offset_z;
    logic [22:0]        cam_distance;
    logic signed [7:0]  character_id;
    logic               teammate;

    assign target_x     = s_tdata[23:0];
    assign target_y     = s_tdata[47:24];
    assign target_z     = s_tdata[71:48];
    assign viewer_x     = s_tdata[95:72];
    assign viewer_y     = s_tdata[119:96];
    assign viewer_z     = s_tdata[143:120];
    assign cam_offset_x = s_tdata[167:144];
    assign cam_offset_y = s_tdata[191:168];
    assign cam_offset_z = s_tdata[215:192];
    assign cam_distance = s_tdata[238:216];
    assign character_id = s_tdata[246:239];
    assign teammate     = s_tuser[0];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb
    begin
        item.en = cfg.plates_enabled;
        item.dx = 25'(target_x) - 25'(viewer_x);
        item.dy = 25'(target_y) - 25'(viewer_y);
        item.dz = 25'(target_z) - 25'(viewer_z);
        item.rx = 26'(target_x) - 26'(viewer_x) - 26'(cam_offset_x);
        item.ry = 26'(target_y) + HEAD_HEIGHT - 26'(viewer_y) - 26'(cam_offset_y);
        item.rz = 26'(target_z) - 26'(viewer_z) - 26'(cam_offset_z);
        item.cx = cam_offset_x;
        item.cz = cam_offset_z;
        item.r  = (cam_distance < MIN_CAM_DISTANCE) ? MIN_CAM_DISTANCE : cam_distance;
        item.icon_valid = cfg.face_icons_ready && !character_id[7]
                          && ({1'b0, character_id} < 9'(ICON_COUNT));
        item.icon_index = item.icon_valid ? character_id : 8'd0;
        item.opponent   = !teammate;
    end

endmodule
`default_nettype wire

/* sv/blp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, for quotients below 2^Q_W.
`default_nettype none
module blp_div #(
    parameter int N_W = 66,
    parameter int D_W = 51,
    parameter int Q_W = blp_pkg::DIV_Q_W
) (
    input  wire logic           clk,
    input  wire logic           adv,
    input  wire logic [N_W-1:0] num,
    input  wire logic [D_W-1:0] den,
    output logic [Q_W-1:0]      quo
);
    logic [N_W-1:0] rem_reg [Q_W-1];
    logic [D_W-1:0] dv_reg  [Q_W-1];
    logic [Q_W-1:0] q_reg   [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [N_W-1:0] r_in;
        logic [D_W-1:0] d_in;
        logic [Q_W-1:0] q_in;
        logic [N_W-1:0] trial;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign r_in = num;
            assign d_in = den;
            assign q_in = '0;
        end
        else
        begin : g_next
            assign r_in = rem_reg[k-1];
            assign d_in = dv_reg[k-1];
            assign q_in = q_reg[k-1];
        end

        assign trial = N_W'(d_in) << B;
        assign ge    = (r_in >= trial);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[k] <= {q_in[Q_W-2:0], ge};
            end
        end

        if (k < Q_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= ge ? r_in - trial : r_in;
                    dv_reg[k]  <= d_in;
                end
            end
        end
    end

    assign quo = q_reg[Q_W-1];

endmodule
`default_nettype wire

/* sv/blp_back.sv */
// Back end: products, tests, scale interpolation and screen division pipeline.
`default_nettype none
module blp_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire blp_pkg::cfg_t                   cfg,
    input  wire logic                            head_valid,
    input  wire blp_pkg::item_t                  head_item,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [blp_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [blp_pkg::OUT_USER_W-1:0]       m_tuser
);
    import blp_pkg::*;

    typedef struct packed {
        logic       vis;
        logic       x_hi;
        logic       x_lo;
        logic       x_neg;
        logic       y_top;
        logic       y_bot;
        logic       y_neg;
        logic       near_hit;
        logic       far_hit;
        logic       sc_down;
        logic       icon_valid;
        logic [7:0] icon_index;
        logic       opponent;
    } side_t;

    logic adv;
    assign adv = !m_tvalid || m_tready;
    assign pop = adv && head_valid;

    // Stage 1: products.
    logic               v1_reg;
    logic               en1_reg;
    logic [49:0]        sqx_reg, sqy_reg, sqz_reg;
    logic signed [49:0] rxcx_reg, rzcz_reg, rxcz_reg, rzcx_reg, ny1_reg;
    logic [22:0]        r1_reg;
    logic               iv1_reg, opp1_reg;
    logic [7:0]         ii1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            en1_reg  <= head_item.en;
            sqx_reg  <= 50'(head_item.dx) * 50'(head_item.dx);
            sqy_reg  <= 50'(head_item.dy) * 50'(head_item.dy);
            sqz_reg  <= 50'(head_item.dz) * 50'(head_item.dz);
            rxcx_reg <= 50'(head_item.rx) * 50'(head_item.cx);
            rzcz_reg <= 50'(head_item.rz) * 50'(head_item.cz);
            rxcz_reg <= 50'(head_item.rx) * 50'(head_item.cz);
            rzcx_reg <= 50'(head_item.rz) * 50'(head_item.cx);
            ny1_reg  <= 50'(head_item.ry) * 50'(head_item.r);
            r1_reg   <= head_item.r;
            iv1_reg  <= head_item.icon_valid;
            ii1_reg  <= head_item.icon_index;
            opp1_reg <= head_item.opponent;
        end
    end

    // Stage 2: sums, visibility and distance band.
    logic [49:0]        dsq_c;
    logic signed [51:0] den_c, side_c, thr_c;
    logic signed [52:0] e_c;
    logic [47:0]        near_q, far_q;

    always_comb
    begin
        dsq_c  = sqx_reg + sqy_reg + sqz_reg;
        den_c  = -(52'(rxcx_reg) + 52'(rzcz_reg));
        side_c = 52'(rxcz_reg) - 52'(rzcx_reg);
        thr_c  = $signed(52'(r1_reg) * 52'd5120);
        e_c    = 53'(den_c) + $signed(53'(r1_reg) * 53'd66560);
        near_q = {cfg.near_distance_sq, 16'd0};
        far_q  = {cfg.far_distance_sq, 16'd0};
    end

    logic               v2_reg;
    logic               vis2_reg, near2_reg, far2_reg;
    logic [47:0]        diffd2_reg, span2_reg;
    logic signed [51:0] den2_reg, side2_reg;
    logic signed [52:0] e2_reg;
    logic signed [49:0] ny2_reg;
    logic               iv2_reg, opp2_reg;
    logic [7:0]         ii2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis2_reg   <= en1_reg && !(dsq_c > {2'b0, cfg.hide_distance_sq, 16'd0})
                          && !(den_c < thr_c);
            near2_reg  <= (dsq_c <= {2'b0, near_q});
            far2_reg   <= (dsq_c >= {2'b0, far_q});
            diffd2_reg <= dsq_c[47:0] - near_q;
            span2_reg  <= far_q - near_q;
            den2_reg   <= den_c;
            side2_reg  <= side_c;
            e2_reg     <= e_c;
            ny2_reg    <= ny1_reg;
            iv2_reg    <= iv1_reg;
            ii2_reg    <= ii1_reg;
            opp2_reg   <= opp1_reg;
        end
    end

    // Stage 3: constant scalings and the scale product.
    logic               v3_reg;
    logic               vis3_reg, near3_reg, far3_reg, down3_reg;
    logic signed [63:0] nx3_reg, lx3_reg, nyv3_reg, lyh3_reg, lyl3_reg;
    logic [63:0]        sprod3_reg;
    logic [47:0]        span3_reg;
    logic [50:0]        den3_reg, e3_reg;
    logic               iv3_reg, opp3_reg;
    logic [7:0]         ii3_reg;
    logic [8:0]         dmag_c;

    assign dmag_c = (cfg.max_scale >= cfg.min_scale) ? cfg.max_scale - cfg.min_scale
                                                     : cfg.min_scale - cfg.max_scale;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis3_reg   <= vis2_reg;
            near3_reg  <= near2_reg;
            far3_reg   <= far2_reg;
            down3_reg  <= (cfg.min_scale < cfg.max_scale);
            nx3_reg    <= 64'(side2_reg) * 64'sd900;
            lx3_reg    <= 64'(den2_reg) * 64'sd880;
            nyv3_reg   <= 64'(ny2_reg) * 64'sd620;
            lyh3_reg   <= 64'(e2_reg) * 64'sd480;
            lyl3_reg   <= 64'(e2_reg) * 64'sd440;
            sprod3_reg <= 64'(dmag_c) * 64'(diffd2_reg);
            span3_reg  <= span2_reg;
            den3_reg   <= den2_reg[50:0];
            e3_reg     <= e2_reg[50:0];
            iv3_reg    <= iv2_reg;
            ii3_reg    <= ii2_reg;
            opp3_reg   <= opp2_reg;
        end
    end

    // Stage 4: box tests and divider operands.
    logic signed [63:0] ax_c, ay_c;
    assign ax_c = nx3_reg[63] ? -nx3_reg : nx3_reg;
    assign ay_c = nyv3_reg[63] ? -nyv3_reg : nyv3_reg;

    logic        v4_reg;
    side_t       side4_reg;
    logic [65:0] numx4_reg, numy4_reg;
    logic [50:0] denx4_reg, deny4_reg;
    logic [63:0] nums4_reg;
    logic [47:0] dens4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side4_reg.vis        <= vis3_reg;
            side4_reg.x_hi       <= (nx3_reg >= lx3_reg);
            side4_reg.x_lo       <= (nx3_reg <= -lx3_reg);
            side4_reg.x_neg      <= nx3_reg[63];
            side4_reg.y_top      <= (nyv3_reg >= lyh3_reg);
            side4_reg.y_bot      <= (nyv3_reg <= -lyl3_reg);
            side4_reg.y_neg      <= nyv3_reg[63];
            side4_reg.near_hit   <= near3_reg;
            side4_reg.far_hit    <= far3_reg;
            side4_reg.sc_down    <= down3_reg;
            side4_reg.icon_valid <= iv3_reg;
            side4_reg.icon_index <= ii3_reg;
            side4_reg.opponent   <= opp3_reg;
            numx4_reg <= {ax_c[61:0], 4'd0};
            numy4_reg <= {ay_c[61:0], 4'd0};
            denx4_reg <= den3_reg;
            deny4_reg <= e3_reg;
            nums4_reg <= sprod3_reg;
            dens4_reg <= span3_reg;
        end
    end

    // Division stages.
    logic [DIV_Q_W-1:0] qx_c, qy_c, qs_c;

    blp_div #(.N_W(66), .D_W(51), .Q_W(DIV_Q_W)) u_div_x (
        .clk (clk), .adv (adv), .num (numx4_reg), .den (denx4_reg), .quo (qx_c)
    );
    blp_div #(.N_W(66), .D_W(51), .Q_W(DIV_Q_W)) u_div_y (
        .clk (clk), .adv (adv), .num (numy4_reg), .den (deny4_reg), .quo (qy_c)
    );
    blp_div #(.N_W(64), .D_W(48), .Q_W(DIV_Q_W)) u_div_s (
        .clk (clk), .adv (adv), .num (nums4_reg), .den (dens4_reg), .quo (qs_c)
    );

    side_t dside_reg [DIV_Q_W];
    logic  dv_reg    [DIV_Q_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dside_reg[0] <= side4_reg;
            for (int i = 1; i < DIV_Q_W; i++)
            begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    // Result assembly.
    side_t              so;
    logic [8:0]         sc_c;
    logic signed [15:0] xoff_c, yoff_c, sl_c, st_c;
    logic [14:0]        left_c;
    logic [13:0]        top_c;
    logic [16:0]        card_c;
    logic [13:0]        icon_c, font_c;

    always_comb
    begin
        so = dside_reg[DIV_Q_W-1];
        if (so.near_hit)
        begin
            sc_c = cfg.max_scale;
        end
        else if (so.far_hit)
        begin
            sc_c = cfg.min_scale;
        end
        else if (so.sc_down)
        begin
            sc_c = cfg.max_scale - qs_c[8:0];
        end
        else
        begin
            sc_c = cfg.max_scale + qs_c[8:0];
        end
        xoff_c = so.x_neg ? -$signed({2'b0, qx_c}) : $signed({2'b0, qx_c});
        yoff_c = so.y_neg ? -$signed({2'b0, qy_c}) : $signed({2'b0, qy_c});
        sl_c   = CENTRE_X_Q4 + xoff_c;
        st_c   = CENTRE_Y_Q4 - yoff_c;
        if (so.x_hi)
        begin
            left_c = LEFT_MAX_Q4;
        end
        else if (so.x_lo)
        begin
            left_c = LEFT_MIN_Q4;
        end
        else
        begin
            left_c = sl_c[14:0];
        end
        if (so.y_top)
        begin
            top_c = TOP_MIN_Q4;
        end
        else if (so.y_bot)
        begin
            top_c = TOP_MAX_Q4;
        end
        else
        begin
            top_c = st_c[13:0];
        end
        card_c = 17'(sc_c) * 17'd220;
        icon_c = 14'(sc_c) * 14'd22;
        font_c = 14'(sc_c) * 14'd20;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (so.vis)
            begin
                m_tdata <= {1'b0, so.icon_index, font_c[13:4], icon_c[13:4], card_c[16:4],
                            sc_c, top_c, left_c};
                m_tuser <= {so.opponent, so.icon_valid, 1'b1};
            end
            else
            begin
                m_tdata <= '0;
                m_tuser <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            m_tvalid <= 1'b0;
            for (int i = 0; i < DIV_Q_W; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= head_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int i = 1; i < DIV_Q_W; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
            m_tvalid <= dv_reg[DIV_Q_W-1];
        end
    end

endmodule
`default_nettype wire

/* sv/billboard_label_projection.sv */
// Top level of the billboard label projection block: configuration and wiring.
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid/s_tready    tdata positions, radius, character; tuser teammate
//  m_*       out        m_tvalid/m_tready    tdata screen and size fields; tuser flags
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One beat is accepted per cycle while the queue is not full; each result passes through
// four arithmetic stages, fourteen one-bit divider stages and the output register.
// Reset clears the queue, the valid chain and the registers to their reset values.
// The back pipeline stalls as a whole while m_tvalid is high and m_tready is low; the queue
// lets the input keep taking beats until it fills.
`default_nettype none
module billboard_label_projection #(
    parameter int ICON_COUNT  = blp_pkg::ICON_COUNT_DEF,
    parameter int QUEUE_DEPTH = blp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // target_x, target_y, target_z, viewer_x, viewer_y, viewer_z,
    // cam_offset_x, cam_offset_y, cam_offset_z, cam_distance, character_id
    input  wire logic [blp_pkg::IN_DATA_W-1:0]  s_tdata,
    // teammate
    input  wire logic [blp_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // screen_left, screen_top, scale_out, card_span, icon_edge, text_size, icon_index
    output logic [blp_pkg::OUT_DATA_W-1:0]      m_tdata,
    // visible, icon_valid, opponent
    output logic [blp_pkg::OUT_USER_W-1:0]      m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [blp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [blp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import blp_pkg::*;

    cfg_t  cfg_reg;
    item_t push_item;
    item_t head_item;
    logic  push, pop, full, head_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plates_enabled   <= 1'b0;
            cfg_reg.face_icons_ready <= 1'b0;
            cfg_reg.hide_distance_sq <= HIDE_DISTANCE_SQ_RST;
            cfg_reg.near_distance_sq <= NEAR_DISTANCE_SQ_RST;
            cfg_reg.far_distance_sq  <= FAR_DISTANCE_SQ_RST;
            cfg_reg.min_scale        <= MIN_SCALE_RST;
            cfg_reg.max_scale        <= MAX_SCALE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PLATES_ENABLED:   cfg_reg.plates_enabled   <= cfg_data[0];
                REG_FACE_ICONS_READY: cfg_reg.face_icons_ready <= cfg_data[0];
                REG_HIDE_DISTANCE_SQ: cfg_reg.hide_distance_sq <= cfg_data;
                REG_NEAR_DISTANCE_SQ: cfg_reg.near_distance_sq <= cfg_data;
                REG_FAR_DISTANCE_SQ:  cfg_reg.far_distance_sq  <= cfg_data;
                REG_MIN_SCALE:        cfg_reg.min_scale        <= cfg_data[8:0];
                REG_MAX_SCALE:        cfg_reg.max_scale        <= cfg_data[8:0];
                default:              ;
            endcase
        end
    end

    blp_front #(.ICON_COUNT(ICON_COUNT)) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg        (cfg_reg),
        .queue_full (full),
        .push       (push),
        .item       (push_item)
    );

    blp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    blp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

/* test/tb_billboard_label_projection.sv */
// Self-checking testbench for the billboard label projection block.
module tb_billboard_label_projection;
    timeunit 1ns;
    timeprecision 1ps;
    import blp_pkg::*;

    typedef struct {
        logic signed [23:0] tx, ty, tz, vx, vy, vz, cx, cy, cz;
        logic [22:0]        radius;
        logic signed [7:0]  character;
        logic               teammate;
    } label_req_t;

    typedef struct packed {
        logic        visible;
        logic [14:0] left;
        logic [13:0] top;
        logic [8:0]  scale;
        logic [12:0] card;
        logic [9:0]  icon;
        logic [9:0]  font;
        logic        icon_valid;
        logic [7:0]  icon_index;
        logic        opponent;
    } label_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [IN_USER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copies used by the predictor.
    cfg_t       regs;
    label_out_t pending_labels[$];
    int         error_count = 0;
    int         label_count = 0;
    int         shown_count = 0;
    bit         quiet = 1'b0;
    int         sink_stall = 0;

    billboard_label_projection dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint frac_q4(input longint num, input longint den);
        longint q;
        q = num / den;
        return q * 16 + ((num - q * den) * 16) / den;
    endfunction

    function automatic label_out_t project_label(input label_req_t a);
        label_out_t o;
        longint dx, dy, dz, dsq, rx, ry, rz, r, den, side, e, ny, nq, fq, sc, sl, st;
        o = '0;
        if (!regs.plates_enabled)
            return o;
        dx = longint'(a.tx) - longint'(a.vx);
        dy = longint'(a.ty) - longint'(a.vy);
        dz = longint'(a.tz) - longint'(a.vz);
        dsq = dx * dx + dy * dy + dz * dz;
        if (dsq > (longint'(regs.hide_distance_sq) <<< 16))
            return o;
        r = longint'({1'b0, a.radius});
        if (r < 256)
            r = 256;
        rx = dx - longint'(a.cx);
        ry = dy + 14080 - longint'(a.cy);
        rz = dz - longint'(a.cz);
        den = -(rx * longint'(a.cx) + rz * longint'(a.cz));
        if (den < 20 * 256 * r)
            return o;
        nq = longint'(regs.near_distance_sq) <<< 16;
        fq = longint'(regs.far_distance_sq) <<< 16;
        if (dsq <= nq)
            sc = regs.max_scale;
        else if (dsq >= fq)
            sc = regs.min_scale;
        else
            sc = longint'(regs.max_scale) + (longint'(regs.min_scale) -
                 longint'(regs.max_scale)) * (dsq - nq) / (fq - nq);
        side = rx * longint'(a.cz) - rz * longint'(a.cx);
        if (900 * side >= 880 * den)
            sl = 1840 * 16;
        else if (900 * side <= -880 * den)
            sl = 80 * 16;
        else
            sl = 960 * 16 + frac_q4(900 * side, den);
        e = den + 66560 * r;
        ny = ry * r;
        if (620 * ny >= 480 * e)
            st = 60 * 16;
        else if (620 * ny <= -440 * e)
            st = 980 * 16;
        else
            st = 540 * 16 - frac_q4(620 * ny, e);
        o.visible = 1'b1;
        o.left = sl[14:0];
        o.top = st[13:0];
        o.scale = sc[8:0];
        o.card = 13'((sc * 220) / 16);
        o.icon = 10'((sc * 22) / 16);
        o.font = 10'((sc * 20) / 16);
        if (regs.face_icons_ready && a.character >= 0 && a.character < ICON_COUNT_DEF)
        begin
            o.icon_valid = 1'b1;
            o.icon_index = a.character;
        end
        o.opponent = ~a.teammate;
        return o;
    endfunction

    task automatic send_label(input label_req_t a);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, a.character, a.radius, a.cz, a.cy, a.cx, a.vz, a.vy, a.vx,
                    a.tz, a.ty, a.tx};
        s_tuser <= a.teammate;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_labels.push_back(project_label(a));
        label_count++;
    endtask

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PLATES_ENABLED:   regs.plates_enabled = value[0];
            REG_FACE_ICONS_READY: regs.face_icons_ready = value[0];
            REG_HIDE_DISTANCE_SQ: regs.hide_distance_sq = value;
            REG_NEAR_DISTANCE_SQ: regs.near_distance_sq = value;
            REG_FAR_DISTANCE_SQ:  regs.far_distance_sq = value;
            REG_MIN_SCALE:        regs.min_scale = value[8:0];
            REG_MAX_SCALE:        regs.max_scale = value[8:0];
            default: ;
        endcase
    endtask

    task automatic drain_labels();
        s_tvalid <= 1'b0;
        while (pending_labels.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic set_limits(input logic en, input logic icons, input logic [31:0] hide,
                              input logic [31:0] near_sq, input logic [31:0] far_sq,
                              input logic [8:0] lo, input logic [8:0] hi);
        drain_labels();
        write_reg(REG_PLATES_ENABLED, {31'd0, en});
        write_reg(REG_FACE_ICONS_READY, {31'd0, icons});
        write_reg(REG_HIDE_DISTANCE_SQ, hide);
        write_reg(REG_NEAR_DISTANCE_SQ, near_sq);
        write_reg(REG_FAR_DISTANCE_SQ, far_sq);
        write_reg(REG_MIN_SCALE, {23'd0, lo});
        write_reg(REG_MAX_SCALE, {23'd0, hi});
        cfg_valid <= 1'b0;
    endtask

    function automatic label_req_t noise_label();
        label_req_t a;
        {a.tx, a.ty, a.tz} = 72'({$urandom, $urandom, $urandom});
        {a.vx, a.vy, a.vz} = 72'({$urandom, $urandom, $urandom});
        {a.cx, a.cy, a.cz} = 72'({$urandom, $urandom, $urandom});
        a.radius = 23'($urandom);
        a.character = 8'($urandom);
        a.teammate = 1'($urandom);
        return a;
    endfunction

    // A plausible scene: target within about 1500 units, camera behind the viewer.
    function automatic label_req_t scene_label();
        label_req_t a;
        int dx, dy, dz, sh;
        a = noise_label();
        dx = ($urandom_range(0, 3000) - 1500) * 256 + $urandom_range(0, 255);
        dy = ($urandom_range(0, 400) - 200) * 256 + $urandom_range(0, 255);
        dz = ($urandom_range(0, 3000) - 1500) * 256 + $urandom_range(0, 255);
        a.vx = 24'($urandom_range(0, 2097152) - 1048576);
        a.vy = 24'($urandom_range(0, 2097152) - 1048576);
        a.vz = 24'($urandom_range(0, 2097152) - 1048576);
        a.tx = 24'(a.vx + dx);
        a.ty = 24'(a.vy + dy);
        a.tz = 24'(a.vz + dz);
        sh = $urandom_range(0, 3);
        a.cx = 24'(-(dx >>> sh) + $urandom_range(0, 4000) - 2000);
        a.cz = 24'(-(dz >>> sh) + $urandom_range(0, 4000) - 2000);
        a.cy = 24'($urandom_range(0, 10000) - 2000);
        a.radius = ($urandom_range(0, 7) == 0) ? 23'($urandom)
                   : 23'($urandom_range(0, 30 * 256));
        a.character = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 40)) : 8'($urandom);
        return a;
    endfunction

    task automatic random_labels(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 4) == 0)
                send_label(noise_label());
            else
                send_label(scene_label());
        end
    endtask

    task automatic test_reset_disabled();
        repeat (6) send_label(scene_label());
    endtask

    task automatic test_field_extremes();
        label_req_t a;
        set_limits(1'b1, 1'b1, 32'hFFFF_FFFF, 32'd160000, 32'd1000000, 9'd115, 9'd294);
        a = noise_label();
        {a.tx, a.ty, a.tz, a.vx, a.vy, a.vz, a.cx, a.cy, a.cz} = {9{24'h7FFFFF}};
        a.radius = 23'h7FFFFF; a.character = 8'sd127; a.teammate = 1'b1;
        send_label(a);
        {a.tx, a.ty, a.tz, a.vx, a.vy, a.vz, a.cx, a.cy, a.cz} = {9{24'h800000}};
        a.radius = '0; a.character = -8'sd128; a.teammate = 1'b0;
        send_label(a);
        a.tx = 24'h7FFFFF; a.vx = 24'h800000;
        send_label(a);
        // Target straight ahead along z, camera behind, camera distance below one unit.
        a = noise_label();
        {a.tx, a.ty, a.tz, a.vx, a.vy, a.vz} = '0;
        a.tz = 24'sd256000; a.cx = '0; a.cy = '0; a.cz = -24'sd25600; a.radius = 23'd10;
        a.character = 8'sd0; send_label(a);
        a.character = 8'sd31; send_label(a);
        a.character = 8'sd32; send_label(a);
        a.character = -8'sd1; send_label(a);
        a.tx = 24'sd2000000; send_label(a);     // clamp left
        a.tx = -24'sd2000000; send_label(a);    // clamp right
        a.tx = '0; a.ty = 24'sd3000000; send_label(a);   // clamp top
        a.ty = -24'sd3000000; send_label(a);            // clamp bottom
        a.ty = '0; a.tz = 24'sd2560; send_label(a);      // close target
        a.tz = 24'sd7680; a.cz = -24'sd256; a.radius = 23'd256; send_label(a);
        repeat (8) send_label(scene_label());
    endtask

    task automatic test_default_limits();
        set_limits(1'b1, 1'b0, HIDE_DISTANCE_SQ_RST, NEAR_DISTANCE_SQ_RST,
                   FAR_DISTANCE_SQ_RST, MIN_SCALE_RST, MAX_SCALE_RST);
        random_labels(60);
        // Let the whole pipeline empty before carrying on.
        drain_labels();
        random_labels(60);
    endtask

    task automatic test_icons_ready();
        set_limits(1'b1, 1'b1, HIDE_DISTANCE_SQ_RST, NEAR_DISTANCE_SQ_RST,
                   FAR_DISTANCE_SQ_RST, MIN_SCALE_RST, MAX_SCALE_RST);
        random_labels(100);
    endtask

    task automatic test_limit_extremes();
        set_limits(1'b1, 1'b1, 32'd0, 32'd0, 32'd1, 9'd0, 9'd511);
        random_labels(30);
        set_limits(1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 9'd511, 9'd0);
        random_labels(60);
        // Near above far: the near test wins.
        set_limits(1'b1, 1'b1, 32'hFFFF_FFFF, 32'd1000000, 32'd200000, 9'd20, 9'd400);
        random_labels(60);
        set_limits(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 9'd511, 9'd511);
        random_labels(30);
        set_limits(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'd1, 9'd0, 9'd0);
        random_labels(30);
    endtask

    task automatic test_random_limits();
        logic [31:0] near_sq;
        repeat (6)
        begin
            near_sq = $urandom_range(0, 2000000);
            set_limits(1'b1, 1'($urandom), ($urandom_range(0, 3) == 0) ? $urandom
                       : $urandom_range(100000, 4000000), near_sq,
                       near_sq + $urandom_range(1, 3000000), 9'($urandom), 9'($urandom));
            random_labels(40);
        end
    endtask

    task automatic test_back_to_back();
        set_limits(1'b1, 1'b1, 32'd2500000, 32'd100000, 32'd2000000, 9'd64, 9'd320);
        quiet = 1'b1;
        random_labels(80);
    endtask

    // Result sink: random stall bursts, none once the quiet stretch starts.
    always @(posedge clk)
    begin
        if (quiet)
            m_tready <= 1'b1;
        else if (sink_stall > 0)
        begin
            sink_stall <= sink_stall - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            sink_stall <= $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            error_count++;
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        label_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_labels.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected beat, expected none actual %h/%h", $time,
                         m_tuser, m_tdata);
            end
            else
            begin
                want = pending_labels.pop_front();
                if (want.visible)
                    shown_count++;
                check_field("visible", want.visible, m_tuser[0]);
                check_field("icon_valid", want.icon_valid, m_tuser[1]);
                check_field("opponent", want.opponent, m_tuser[2]);
                check_field("screen_left", want.left, m_tdata[14:0]);
                check_field("screen_top", want.top, m_tdata[28:15]);
                check_field("scale_out", want.scale, m_tdata[37:29]);
                check_field("card_span", want.card, m_tdata[50:38]);
                check_field("icon_edge", want.icon, m_tdata[60:51]);
                check_field("text_size", want.font, m_tdata[70:61]);
                check_field("icon_index", want.icon_index, m_tdata[78:71]);
            end
        end
    end

    initial
    begin
        regs = '{1'b0, 1'b0, HIDE_DISTANCE_SQ_RST, NEAR_DISTANCE_SQ_RST,
                 FAR_DISTANCE_SQ_RST, MIN_SCALE_RST, MAX_SCALE_RST};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_disabled();
        test_field_extremes();
        test_default_limits();
        test_icons_ready();
        test_limit_extremes();
        test_random_limits();
        test_back_to_back();
        drain_labels();
        if (pending_labels.size() != 0)
            error_count++;
        $display("Sent %0d labels, %0d shown, across reset, extreme and random limits.",
                 label_count, shown_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
